@@ src/weighted_digraph_edge_store_core_assert.svh @@
// ----------------------------------------------------------------------------
// weighted_digraph_edge_store_core_assert.svh
// assertion macros shared by the edge store rtl
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_DIGRAPH_EDGE_STORE_CORE_ASSERT_SVH
`define WEIGHTED_DIGRAPH_EDGE_STORE_CORE_ASSERT_SVH

// same-cycle implication
`define WDES_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, the consequent may carry a further delay
`define WDES_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

@@ src/wdes_pkg.sv @@
// ----------------------------------------------------------------------------
// wdes_pkg
// types, codes and defaults of the weighted digraph edge store
// ----------------------------------------------------------------------------
`default_nettype none

package wdes_pkg;

   localparam int VERTEX_COUNT_DEF = 64;
   localparam int WEIGHT_BITS_DEF  = 32;
   localparam int ACTION_W         = 3;
   localparam int VERTEX_ID_W      = 6;
   localparam int WEIGHT_IO_W      = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD_VERTEX    = 3'd0,
      ACT_REMOVE_VERTEX = 3'd1,
      ACT_ADD_EDGE      = 3'd2,
      ACT_REMOVE_EDGE   = 3'd3,
      ACT_READ_EDGE     = 3'd4,
      ACT_TOGGLE_INVERT = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic exec;
      logic walk_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_start;
      logic walk_done;
   } ctrl_status_type;

endpackage

`default_nettype wire

@@ src/weighted_digraph_edge_store_core.sv @@
// ----------------------------------------------------------------------------
// weighted_digraph_edge_store_core
// directed weighted graph held as an adjacency matrix in block memory
// ----------------------------------------------------------------------------
// usage:
//  - a request word is taken at a clock edge with start high and busy low:
//    action, vertex_a, vertex_b and edge_weight_in
//  - every request gives exactly one result word on rsp_status, rsp_found
//    and rsp_edge_weight_out, shown for one cycle with rsp_valid high
//  - the result is registered from the execute state that follows the
//    accepting edge; busy is high in that state, so requests do not overlap
//  - a successful remove vertex also walks its matrix row and column, one edge memory
//    write per cycle, keeping busy high until the walk is done
//  - the single write port of the edge memory shapes this schedule: each
//    request is one registered read and at most one write when it executes
//  - after reset a clearing pass writes every edge slot (and the vertex
//    table along the way): busy stays high until the pass is done
//  - the receiver cannot stall, results must be taken when rsp_valid is high
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_digraph_edge_store_core #(
   parameter int VERTEX_COUNT = wdes_pkg::VERTEX_COUNT_DEF,
   parameter int WEIGHT_BITS  = wdes_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic        [wdes_pkg::ACTION_W-1:0]    req_action,
   input  wire logic        [wdes_pkg::VERTEX_ID_W-1:0] req_vertex_a,
   input  wire logic        [wdes_pkg::VERTEX_ID_W-1:0] req_vertex_b,
   input  wire logic signed [wdes_pkg::WEIGHT_IO_W-1:0] req_edge_weight_in,
   output logic                                         rsp_valid,
   output logic                                         rsp_status,
   output logic                                         rsp_found,
   output logic signed      [wdes_pkg::WEIGHT_IO_W-1:0] rsp_edge_weight_out
);

   import wdes_pkg::*;

   `include "weighted_digraph_edge_store_core_assert.svh"

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   wdes_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   wdes_datapath #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_vertex_a        (req_vertex_a),
      .req_vertex_b        (req_vertex_b),
      .req_edge_weight_in  (req_edge_weight_in),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_found           (rsp_found),
      .rsp_edge_weight_out (rsp_edge_weight_out)
   );

   // ---------------- assertions
   `WDES_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after accept")
   `WDES_ASSERT_NEXT(a_accept_rsp, clock, reset, start && !busy, ##1 rsp_valid, "no result two cycles after accept")
   `WDES_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `WDES_ASSERT_SAME(a_found_ok, clock, reset, rsp_valid && rsp_found, !rsp_status, "found with error status")

endmodule

`default_nettype wire

@@ src/wdes_ram.sv @@
// ----------------------------------------------------------------------------
// wdes_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wdes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/wdes_ctrl.sv @@
// ----------------------------------------------------------------------------
// wdes_ctrl
// sequencer: clearing pass, request accept, execute, vertex removal walk
// ----------------------------------------------------------------------------
`default_nettype none

module wdes_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   output wdes_pkg::ctrl_cmd_type         cmd,
   input  wire wdes_pkg::ctrl_status_type status
);

   import wdes_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.walk_start ? ST_WALK : ST_IDLE;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/wdes_datapath.sv @@
// ----------------------------------------------------------------------------
// wdes_datapath
// request registers, vertex and edge memories, counters and result word
// ----------------------------------------------------------------------------
`default_nettype none

module wdes_datapath #(
   parameter int VERTEX_COUNT = wdes_pkg::VERTEX_COUNT_DEF,
   parameter int WEIGHT_BITS  = wdes_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire wdes_pkg::ctrl_cmd_type                  cmd,
   output wdes_pkg::ctrl_status_type                    status,
   input  wire logic        [wdes_pkg::ACTION_W-1:0]    req_action,
   input  wire logic        [wdes_pkg::VERTEX_ID_W-1:0] req_vertex_a,
   input  wire logic        [wdes_pkg::VERTEX_ID_W-1:0] req_vertex_b,
   input  wire logic signed [wdes_pkg::WEIGHT_IO_W-1:0] req_edge_weight_in,
   output logic                                         rsp_valid,
   output logic                                         rsp_status,
   output logic                                         rsp_found,
   output logic signed      [wdes_pkg::WEIGHT_IO_W-1:0] rsp_edge_weight_out
);

   import wdes_pkg::*;

   localparam int VAW   = $clog2(VERTEX_COUNT);
   localparam int SLOTS = VERTEX_COUNT * VERTEX_COUNT;
   localparam int EAW   = $clog2(SLOTS);
   localparam int WCW   = VAW + 1;
   localparam int IXW   = VERTEX_ID_W + VAW;
   localparam int WIDE  = (WEIGHT_BITS > WEIGHT_IO_W) ? WEIGHT_BITS : WEIGHT_IO_W;

   // ---------------- accept side decode
   logic                   is_edge_act;
   logic [VERTEX_ID_W-1:0] src_id;
   logic [VERTEX_ID_W-1:0] dst_id;
   logic [IXW-1:0]         src_ext;
   logic [IXW-1:0]         dst_ext;
   logic [VAW-1:0]         src_addr;
   logic [VAW-1:0]         dst_addr;
   logic                   src_ok;
   logic                   dst_ok;
   logic [EAW-1:0]         idx_in;
   logic signed [WIDE-1:0] weight_wide;

   logic                   inv_ff;

   assign is_edge_act = (req_action == ACT_ADD_EDGE) || (req_action == ACT_REMOVE_EDGE)
                        || (req_action == ACT_READ_EDGE);
   // the source id swaps only for edge actions while inverted; the destination id swaps whenever inverted
   assign src_id   = (is_edge_act && inv_ff) ? req_vertex_b : req_vertex_a;
   assign dst_id   = inv_ff ? req_vertex_a : req_vertex_b;
   assign src_ext  = IXW'(src_id);
   assign dst_ext  = IXW'(dst_id);
   assign src_addr = src_ext[VAW-1:0];
   assign dst_addr = dst_ext[VAW-1:0];
   assign src_ok   = src_ext < IXW'(VERTEX_COUNT);
   assign dst_ok   = dst_ext < IXW'(VERTEX_COUNT);
   assign idx_in   = EAW'(src_addr * VERTEX_COUNT + dst_addr);
   assign weight_wide = WIDE'(req_edge_weight_in);

   // ---------------- request registers
   logic [ACTION_W-1:0]           act_ff;
   logic [VAW-1:0]                vaddr_ff;
   logic                          a_ok_ff;
   logic                          sd_ok_ff;
   logic [EAW-1:0]                idx_ff;
   logic signed [WEIGHT_BITS-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff    <= req_action;
         vaddr_ff  <= src_addr;
         a_ok_ff   <= src_ok;
         sd_ok_ff  <= src_ok && dst_ok;
         idx_ff    <= idx_in;
         weight_ff <= weight_wide[WEIGHT_BITS-1:0];
      end
   end

   // ---------------- memories
   logic                   e_we;
   logic [EAW-1:0]         e_wa;
   logic [WEIGHT_BITS:0]   e_wd;
   logic [WEIGHT_BITS:0]   e_rd;
   logic                   v_we;
   logic [VAW-1:0]         v_wa;
   logic [0:0]             v_wd;
   logic [0:0]             vp_src_rd;
   logic [0:0]             vp_dst_rd;

   wdes_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(SLOTS)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_wa),
      .wr_data (e_wd),
      .rd_en   (cmd.accept),
      .rd_addr (idx_in),
      .rd_data (e_rd)
   );

   // two copies of the vertex table so both endpoints read in the same cycle
   wdes_ram #(.WIDTH(1), .DEPTH(VERTEX_COUNT)) u_vertex_ram_src (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_wa),
      .wr_data (v_wd),
      .rd_en   (cmd.accept),
      .rd_addr (src_addr),
      .rd_data (vp_src_rd)
   );

   wdes_ram #(.WIDTH(1), .DEPTH(VERTEX_COUNT)) u_vertex_ram_dst (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_wa),
      .wr_data (v_wd),
      .rd_en   (cmd.accept),
      .rd_addr (dst_addr),
      .rd_data (vp_dst_rd)
   );

   // ---------------- counters
   logic [EAW-1:0] clr_ff;
   logic [WCW-1:0] walk_ff;
   logic [VAW-1:0] walk_k;
   logic [EAW-1:0] walk_addr;
   logic           clr_done;
   logic           walk_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         walk_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.exec) begin
            walk_ff <= '0;
         end else if (cmd.walk_step) begin
            walk_ff <= walk_ff + 1'b1;
         end
      end
   end

   // even steps clear the row entry, odd steps the column entry
   assign walk_k    = walk_ff[VAW:1];
   assign walk_addr = walk_ff[0] ? EAW'(walk_k * VERTEX_COUNT + vaddr_ff)
                                 : EAW'(vaddr_ff * VERTEX_COUNT + walk_k);

   assign clr_done  = clr_ff == EAW'(SLOTS - 1);
   assign walk_done = walk_ff == WCW'(2 * VERTEX_COUNT - 1);

   // ---------------- execute
   logic                          edge_hit;
   logic signed [WEIGHT_BITS-1:0] stored_weight;
   logic signed [WIDE-1:0]        stored_wide;
   logic                          keep_old;
   logic                          ex_status;
   logic                          ex_found;
   logic                          ex_e_we;
   logic                          ex_e_valid;
   logic                          ex_v_we;
   logic                          ex_v_val;
   logic                          ex_walk_start;

   assign edge_hit      = e_rd[WEIGHT_BITS];
   assign stored_weight = e_rd[WEIGHT_BITS-1:0];
   assign stored_wide   = WIDE'(stored_weight);
   assign keep_old      = edge_hit && (stored_weight < weight_ff);

   always_comb begin
      ex_status     = 1'b1;
      ex_found      = 1'b0;
      ex_e_we       = 1'b0;
      ex_e_valid    = 1'b0;
      ex_v_we       = 1'b0;
      ex_v_val      = 1'b0;
      ex_walk_start = 1'b0;
      case (act_ff)
         ACT_ADD_VERTEX: begin
            if (a_ok_ff && !vp_src_rd[0]) begin
               ex_status = 1'b0;
               ex_v_we   = 1'b1;
               ex_v_val  = 1'b1;
            end
         end
         ACT_REMOVE_VERTEX: begin
            if (a_ok_ff && vp_src_rd[0]) begin
               ex_status     = 1'b0;
               ex_v_we       = 1'b1;
               ex_walk_start = 1'b1;
            end
         end
         ACT_ADD_EDGE: begin
            if (sd_ok_ff && vp_src_rd[0] && vp_dst_rd[0]) begin
               ex_status  = 1'b0;
               ex_e_we    = !keep_old;
               ex_e_valid = 1'b1;
            end
         end
         ACT_REMOVE_EDGE: begin
            if (sd_ok_ff && edge_hit) begin
               ex_status = 1'b0;
               ex_e_we   = 1'b1;
            end
         end
         ACT_READ_EDGE: begin
            if (sd_ok_ff && edge_hit) begin
               ex_status = 1'b0;
               ex_found  = 1'b1;
            end
         end
         ACT_TOGGLE_INVERT: begin
            ex_status = 1'b0;
         end
         default: begin
            ex_status = 1'b1;
         end
      endcase
   end

   // field order: clear_done, walk_start, walk_done
   assign status = {clr_done, ex_walk_start, walk_done};

   // write port arbitration
   always_comb begin
      e_we = 1'b0;
      e_wa = idx_ff;
      e_wd = {ex_e_valid, weight_ff};
      v_we = 1'b0;
      v_wa = vaddr_ff;
      v_wd = ex_v_val;
      if (cmd.clear_step) begin
         e_we = 1'b1;
         e_wa = clr_ff;
         e_wd = '0;
         v_we = clr_ff < EAW'(VERTEX_COUNT);
         v_wa = clr_ff[VAW-1:0];
         v_wd = 1'b0;
      end else if (cmd.walk_step) begin
         e_we = 1'b1;
         e_wa = walk_addr;
         e_wd = '0;
      end else if (cmd.exec) begin
         e_we = ex_e_we;
         v_we = ex_v_we;
      end
   end

   // ---------------- invert flag and result word
   logic                          rsp_valid_ff;
   logic                          rsp_status_ff;
   logic                          rsp_found_ff;
   logic signed [WEIGHT_IO_W-1:0] rsp_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
         if (cmd.exec && (act_ff == ACT_TOGGLE_INVERT)) begin
            inv_ff <= !inv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= ex_status;
         rsp_found_ff  <= ex_found;
         rsp_weight_ff <= ex_found ? stored_wide[WEIGHT_IO_W-1:0] : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_edge_weight_out = rsp_weight_ff;

endmodule

`default_nettype wire
